FILE: rtl/status_frame_decoder_unit_defines.svh
// ----------------------------------------------------------------------------
// Status frame decoder assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef STATUS_FRAME_DECODER_UNIT_DEFINES_SVH
`define STATUS_FRAME_DECODER_UNIT_DEFINES_SVH

// cond must hold at every clock edge
`define SFD_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// cons must hold whenever ante holds
`define SFD_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: rtl/sfd_pkg.sv
// ----------------------------------------------------------------------------
// Status frame decoder package
// Shared types, protocol constants and descriptor helper functions.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int SFD_BUFFER_BYTES = 64;
  localparam int DESC_W = 7;
  localparam int DIV_W  = 27;

  localparam logic [7:0] HDR_BYTE1   = 8'h82;
  localparam logic [7:0] HDR_BYTE2   = 8'hA4;
  localparam logic [7:0] KIND_FORMAT = 8'h00;
  localparam logic [7:0] KIND_VALUES = 8'h01;
  localparam logic [7:0] DT_SPECIAL  = 8'h5B;

  localparam logic [1:0] LEN_1B = 2'd0;
  localparam logic [1:0] LEN_2B = 2'd1;
  localparam logic [1:0] LEN_4B = 2'd2;

  localparam logic [2:0] OUTCOME_NONE     = 3'd0;
  localparam logic [2:0] ST_FORMAT_STORED = 3'd0;
  localparam logic [2:0] ST_VALUES_DONE   = 3'd1;
  localparam logic [2:0] ST_BAD_HEADER    = 3'd2;
  localparam logic [2:0] ST_TOO_SHORT     = 3'd3;
  localparam logic [2:0] ST_NO_FORMAT     = 3'd4;
  localparam logic [2:0] ST_TRUNCATED     = 3'd5;

  typedef enum logic [1:0] {
    FK_NONE,
    FK_HEADER,
    FK_FORMAT,
    FK_VALUES
  } frame_kind_t;

  typedef enum logic {
    RK_VALUE,
    RK_STATUS
  } result_kind_t;

  // descriptor: [6] signed, [5:2] divider index, [1:0] length code
  function automatic logic [DESC_W-1:0] desc_encode(input logic [7:0] dt);
    logic [1:0] code;
    code = LEN_1B;
    unique case (dt[6:4])
      3'd1:       code = LEN_2B;
      3'd2, 3'd7: code = LEN_4B;
      default:    code = LEN_1B;
    endcase
    if (dt == DT_SPECIAL) begin
      return {1'b0, 4'hB, LEN_2B};
    end
    return {dt[7], dt[3:0], code};
  endfunction

  function automatic logic [2:0] desc_bytes(input logic [1:0] code);
    logic [2:0] n;
    unique case (code)
      LEN_1B:  n = 3'd1;
      LEN_2B:  n = 3'd2;
      default: n = 3'd4;
    endcase
    return n;
  endfunction

  function automatic logic [DIV_W-1:0] divider_of(input logic [3:0] idx);
    logic [DIV_W-1:0] d;
    unique case (idx)
      4'd0:  d = 27'd1;
      4'd1:  d = 27'd10;
      4'd2:  d = 27'd100;
      4'd3:  d = 27'd1000;
      4'd4:  d = 27'd10000;
      4'd5:  d = 27'd100000;
      4'd6:  d = 27'd1000000;
      4'd7:  d = 27'd10000000;
      4'd8:  d = 27'd100000000;
      4'd14: d = 27'd256;
      4'd15: d = 27'd2;
      default: d = 27'd1;
    endcase
    return d;
  endfunction

endpackage

FILE: rtl/sfd_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/status_frame_decoder_unit.sv
// ----------------------------------------------------------------------------
// Status frame decoder
// Checks the header of a fan controller status reply, stores format frames
// in a descriptor table and decodes values frames with it.
// ----------------------------------------------------------------------------
// channel   handshake                   payload
// byte      byte_valid / byte_ready     rx_byte, frame_start, frame_length
// result    result_valid / result_ready result_kind .. item_count
//
// One byte per cycle unless stalled; a result is registered and shows in the
// cycle after its byte is taken. The table read is addressed by vnum_next.
// Reset clears frame state; the table is not cleared.
// byte_ready drops only while a result waits for result_ready.
// ----------------------------------------------------------------------------
`include "status_frame_decoder_unit_defines.svh"

module status_frame_decoder_unit import sfd_pkg::*; #(
  parameter int BUFFER_BYTES = SFD_BUFFER_BYTES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_ready,
  input  logic [7:0]         rx_byte,
  input  logic               frame_start,
  input  logic [6:0]         frame_length,
  output logic               result_valid,
  input  logic               result_ready,
  output logic               result_kind,
  output logic [5:0]         value_index,
  output logic [31:0]        value_raw,
  output logic signed [31:0] value_ext,
  output logic [DIV_W-1:0]   divider,
  output logic               sign_flag,
  output logic               scaled_flag,
  output logic [2:0]         byte_length,
  output logic [2:0]         frame_status,
  output logic [6:0]         item_count
);

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int FLEN_CAP_I = (BUFFER_BYTES > 127) ? 127 : BUFFER_BYTES;
  localparam logic [6:0] FLEN_CAP  = 7'(FLEN_CAP_I);
  localparam logic [8:0] BUF_DEPTH = 9'(BUFFER_BYTES);

  frame_kind_t kind, kind_next;
  logic [6:0]  pos, pos_next;
  logic [6:0]  flen, flen_next;
  logic [2:0]  outcome, outcome_next;
  logic [7:0]  announced, announced_next;
  logic [7:0]  dcount, dcount_next;
  logic        fvalid, fvalid_next;
  logic [7:0]  vnum, vnum_next;
  logic [7:0]  limit, limit_next;
  logic [31:0] acc, acc_next;
  logic [2:0]  left, left_next;

  logic              accept, active, produce;
  logic [6:0]        fl_clamp;
  frame_kind_t       cur_kind;
  logic [6:0]        cur_pos, cur_flen;
  logic [2:0]        cur_outcome, cur_left;
  logic [7:0]        cur_vnum, cur_limit;
  logic [31:0]       cur_acc;
  logic              in_data, is_last, p_is5, p_ge6;
  logic [6:0]        didx;
  logic [AW-1:0]     desc_waddr;
  logic [DESC_W-1:0] desc_rdata;
  logic [2:0]        desc_len;
  logic              val_step, val_new, val_skip, trunc, val_take, emit;
  logic [2:0]        left_eff, left_after;
  logic [31:0]       acc_new;
  logic              hdr_bad, no_fmt, fmt_write;
  logic [DIV_W-1:0]  div_val;

  logic              res_kind;
  logic [5:0]        res_index;
  logic [31:0]       res_raw, res_signed;
  logic [DIV_W-1:0]  res_div;
  logic              res_is_signed, res_is_float;
  logic [2:0]        res_len, res_status;
  logic [6:0]        res_count;

  assign byte_ready = !result_valid || result_ready;
  assign accept     = byte_valid && byte_ready;
  assign active     = accept && (frame_start || kind != FK_NONE);

  assign fl_clamp = (frame_length == 7'd0) ? 7'd1 :
                    ((frame_length > FLEN_CAP) ? FLEN_CAP : frame_length);

  // a start byte restarts the frame before it is processed
  assign cur_kind    = frame_start ? FK_HEADER : kind;
  assign cur_pos     = frame_start ? 7'd0 : pos;
  assign cur_flen    = frame_start ? fl_clamp : flen;
  assign cur_outcome = frame_start ? OUTCOME_NONE : outcome;
  assign cur_left    = frame_start ? 3'd0 : left;
  assign cur_vnum    = frame_start ? 8'd0 : vnum;
  assign cur_limit   = frame_start ? 8'd0 : limit;
  assign cur_acc     = frame_start ? 32'd0 : acc;

  assign in_data = (cur_flen >= 7'd7) && ({1'b0, cur_pos} + 8'd2 <= {1'b0, cur_flen});
  assign is_last = ({1'b0, cur_pos} + 8'd1 >= {1'b0, cur_flen});
  assign p_is5   = (cur_pos == 7'd5);
  assign p_ge6   = (cur_pos >= 7'd6);
  assign didx    = cur_pos - 7'd6;
  assign desc_waddr = AW'(didx);

  assign desc_len = desc_bytes(desc_rdata[1:0]);
  assign div_val  = divider_of(desc_rdata[5:2]);

  assign val_step = in_data && cur_kind == FK_VALUES && p_ge6;
  assign val_new  = val_step && cur_left == 3'd0;
  assign val_skip = val_new && cur_vnum >= cur_limit;
  assign trunc    = val_new && !val_skip &&
                    ({1'b0, cur_pos} + {5'd0, desc_len} > {1'b0, cur_flen} - 8'd1);
  assign val_take = val_step && !val_skip && !trunc;
  assign left_eff   = val_new ? desc_len : cur_left;
  assign left_after = left_eff - 3'd1;
  assign acc_new    = {(val_new ? 24'd0 : cur_acc[23:0]), rx_byte};
  assign emit       = val_take && left_after == 3'd0;

  assign hdr_bad = in_data && cur_kind == FK_HEADER && cur_outcome == OUTCOME_NONE &&
                   ((cur_pos == 7'd1 && rx_byte != HDR_BYTE1) ||
                    (cur_pos == 7'd2 && rx_byte != HDR_BYTE2) ||
                    (cur_pos == 7'd3 && rx_byte != KIND_FORMAT && rx_byte != KIND_VALUES));
  assign no_fmt  = in_data && cur_kind == FK_VALUES && p_is5 &&
                   (!fvalid || dcount == 8'd0);
  assign fmt_write = active && in_data && cur_kind == FK_FORMAT && p_ge6 &&
                     ({1'b0, didx} < announced) && ({2'b0, didx} < BUF_DEPTH);

  sfd_ram #(
    .WIDTH (DESC_W),
    .DEPTH (BUFFER_BYTES)
  ) u_desc_ram (
    .clk   (clk),
    .we    (fmt_write),
    .waddr (desc_waddr),
    .wdata (desc_encode(rx_byte)),
    .raddr (vnum_next[AW-1:0]),
    .rdata (desc_rdata)
  );

  // frame kind
  always_comb begin
    kind_next = kind;
    if (active) begin
      kind_next = cur_kind;
      if (in_data && cur_kind == FK_HEADER && cur_outcome == OUTCOME_NONE &&
          cur_pos == 7'd3) begin
        if (rx_byte == KIND_FORMAT) begin
          kind_next = FK_FORMAT;
        end else if (rx_byte == KIND_VALUES) begin
          kind_next = FK_VALUES;
        end
      end
      if (no_fmt || trunc) begin
        kind_next = FK_HEADER;
      end
      if (is_last) begin
        kind_next = FK_NONE;
      end
    end
  end

  // frame datapath
  always_comb begin
    pos_next       = pos;
    flen_next      = flen;
    outcome_next   = outcome;
    announced_next = announced;
    dcount_next    = dcount;
    fvalid_next    = fvalid;
    vnum_next      = vnum;
    limit_next     = limit;
    acc_next       = acc;
    left_next      = left;
    if (active) begin
      pos_next     = is_last ? cur_pos : cur_pos + 7'd1;
      flen_next    = cur_flen;
      outcome_next = cur_outcome;
      vnum_next    = cur_vnum;
      limit_next   = cur_limit;
      acc_next     = cur_acc;
      left_next    = cur_left;
      if (hdr_bad) begin
        outcome_next = ST_BAD_HEADER;
      end
      if (no_fmt) begin
        outcome_next = ST_NO_FORMAT;
      end
      if (trunc) begin
        outcome_next = ST_TRUNCATED;
      end
      if (in_data && p_is5 && (cur_kind == FK_FORMAT || cur_kind == FK_VALUES)) begin
        announced_next = rx_byte;
      end
      if (in_data && p_is5 && cur_kind == FK_FORMAT) begin
        dcount_next = 8'd0;
        fvalid_next = 1'b0;
      end
      if (fmt_write) begin
        dcount_next = {1'b0, didx} + 8'd1;
      end
      if (in_data && p_is5 && cur_kind == FK_VALUES && !no_fmt) begin
        limit_next = (rx_byte < dcount) ? rx_byte : dcount;
      end
      if (val_take) begin
        acc_next  = acc_new;
        left_next = left_after;
        if (emit) begin
          vnum_next = cur_vnum + 8'd1;
        end
      end
      if (is_last && cur_kind == FK_FORMAT) begin
        fvalid_next = 1'b1;
      end
    end
  end

  // result fields
  always_comb begin
    produce       = active && (emit || is_last);
    res_kind      = RK_VALUE;
    res_index     = '0;
    res_raw       = '0;
    res_signed    = '0;
    res_div       = '0;
    res_is_signed = 1'b0;
    res_is_float  = 1'b0;
    res_len       = '0;
    res_status    = '0;
    res_count     = '0;
    if (is_last) begin
      res_kind  = RK_STATUS;
      res_count = (cur_kind == FK_FORMAT) ? dcount[6:0] : cur_vnum[6:0];
      if (cur_flen < 7'd7) begin
        res_status = (cur_flen >= 7'd3) ? ST_BAD_HEADER : ST_TOO_SHORT;
      end else begin
        unique case (cur_kind)
          FK_FORMAT: res_status = ST_FORMAT_STORED;
          FK_VALUES: res_status = (cur_vnum >= cur_limit) ? ST_VALUES_DONE : ST_TRUNCATED;
          default:   res_status = cur_outcome;
        endcase
      end
    end else begin
      res_index     = cur_vnum[5:0];
      res_raw       = acc_new;
      res_signed    = acc_new;
      res_div       = div_val;
      res_is_signed = desc_rdata[6];
      res_is_float  = (div_val != 27'd1);
      res_len       = desc_len;
      if (desc_rdata[6] && desc_rdata[1:0] == LEN_1B && acc_new[7]) begin
        res_signed = acc_new | 32'hFFFF_FF00;
      end
      if (desc_rdata[6] && desc_rdata[1:0] == LEN_2B && acc_new[15]) begin
        res_signed = acc_new | 32'hFFFF_0000;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kind      <= FK_NONE;
      pos       <= '0;
      flen      <= 7'd1;
      outcome   <= OUTCOME_NONE;
      announced <= '0;
      dcount    <= '0;
      fvalid    <= 1'b0;
      vnum      <= '0;
      limit     <= '0;
      acc       <= '0;
      left      <= '0;
    end else begin
      kind      <= kind_next;
      pos       <= pos_next;
      flen      <= flen_next;
      outcome   <= outcome_next;
      announced <= announced_next;
      dcount    <= dcount_next;
      fvalid    <= fvalid_next;
      vnum      <= vnum_next;
      limit     <= limit_next;
      acc       <= acc_next;
      left      <= left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (byte_ready) begin
      result_valid <= produce;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_ready) begin
      result_kind  <= res_kind;
      value_index  <= res_index;
      value_raw    <= res_raw;
      value_ext    <= res_signed;
      divider      <= res_div;
      sign_flag    <= res_is_signed;
      scaled_flag  <= res_is_float;
      byte_length  <= res_len;
      frame_status <= res_status;
      item_count   <= res_count;
    end
  end

  `SFD_ASSERT_IMPLIES(a_idle_no_partial, kind == FK_NONE, left == 3'd0, "partial value outside frame")
  `SFD_ASSERT_HOLDS(a_vnum_in_limit, vnum <= limit, "value number past value limit")
  `SFD_ASSERT_IMPLIES(a_value_fields, result_valid && result_kind == RK_VALUE, divider != '0 && byte_length != 3'd0 && item_count == 7'd0, "malformed value request")

endmodule

FILE: bench/status_frame_decoder_unit_checker.sv
// ----------------------------------------------------------------------------
// Status frame decoder checker
// Watches both channels, decodes every accepted reply byte with its own
// model of the header, format and values frames, and compares each
// accepted result field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module status_frame_decoder_unit_checker import sfd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  input  logic               byte_ready,
  input  logic [7:0]         rx_byte,
  input  logic               frame_start,
  input  logic [6:0]         frame_length,
  input  logic               result_valid,
  input  logic               result_ready,
  input  logic               result_kind,
  input  logic [5:0]         value_index,
  input  logic [31:0]        value_raw,
  input  logic signed [31:0] value_ext,
  input  logic [DIV_W-1:0]   divider,
  input  logic               sign_flag,
  input  logic               scaled_flag,
  input  logic [2:0]         byte_length,
  input  logic [2:0]         frame_status,
  input  logic [6:0]         item_count,
  output int                 mismatches,
  output int                 results_due
);

  localparam logic [DIV_W-1:0] SCALE_BY_INDEX [16] = '{
    27'd1, 27'd10, 27'd100, 27'd1000, 27'd10000, 27'd100000, 27'd1000000,
    27'd10000000, 27'd100000000, 27'd1, 27'd1, 27'd1, 27'd1, 27'd1, 27'd256, 27'd2
  };

  typedef struct packed {
    logic             kind;
    logic [5:0]       index;
    logic [31:0]      raw;
    logic [31:0]      sval;
    logic [DIV_W-1:0] div;
    logic             sgn;
    logic             flt;
    logic [2:0]       blen;
    logic [2:0]       status;
    logic [6:0]       count;
  } decoded_t;

  decoded_t decoded_results[$];

  logic [DESC_W-1:0] desc_table [SFD_BUFFER_BYTES];
  int                desc_count;
  bit                format_ok;
  int                byte_pos;
  frame_kind_t       phase;
  logic [7:0]        announced;
  logic [31:0]       accum;
  int                value_num;
  int                bytes_left;
  logic [2:0]        outcome;
  int                frame_len;
  int                value_cap;

  function automatic logic [DESC_W-1:0] pack_descriptor(input logic [7:0] dt);
    logic [1:0] code;
    if (dt == DT_SPECIAL) return {1'b0, 4'hB, LEN_2B};
    case (dt[6:4])
      3'd1:       code = LEN_2B;
      3'd2, 3'd7: code = LEN_4B;
      default:    code = LEN_1B;
    endcase
    return {dt[7], dt[3:0], code};
  endfunction

  function automatic int value_bytes(input logic [1:0] code);
    return (code == LEN_1B) ? 1 : ((code == LEN_2B) ? 2 : 4);
  endfunction

  task automatic decode_reply_byte(input logic [7:0] b, input logic start,
                                   input logic [6:0] len);
    int p;
    int n;
    int cnt;
    bit emit;
    bit go;
    logic [DESC_W-1:0] d;
    logic [31:0] sv;
    logic [DIV_W-1:0] scale;
    logic [2:0] st;
    decoded_t r;
    emit = 1'b0;
    r = '0;
    if (start) begin
      frame_len = (len == 0) ? 1 : ((len > SFD_BUFFER_BYTES) ? SFD_BUFFER_BYTES : len);
      byte_pos = 0;
      phase = FK_HEADER;
      outcome = OUTCOME_NONE;
      accum = '0;
      value_num = 0;
      bytes_left = 0;
      value_cap = 0;
    end else if (phase == FK_NONE) begin
      return;
    end
    p = byte_pos;
    if (frame_len >= 7 && p + 2 <= frame_len) begin
      case (phase)
        FK_HEADER: begin
          if (outcome == OUTCOME_NONE) begin
            if ((p == 1 && b != HDR_BYTE1) || (p == 2 && b != HDR_BYTE2))
              outcome = ST_BAD_HEADER;
            if (p == 3) begin
              if (b == KIND_FORMAT) phase = FK_FORMAT;
              else if (b == KIND_VALUES) phase = FK_VALUES;
              else outcome = ST_BAD_HEADER;
            end
          end
        end
        FK_FORMAT: begin
          if (p == 5) begin
            announced = b;
            desc_count = 0;
            format_ok = 1'b0;
          end else if (p >= 6) begin
            if (p - 6 < announced && p - 6 < SFD_BUFFER_BYTES) begin
              desc_table[p - 6] = pack_descriptor(b);
              desc_count = p - 5;
            end
          end
        end
        FK_VALUES: begin
          if (p == 5) begin
            announced = b;
            if (!format_ok || desc_count == 0) begin
              phase = FK_HEADER;
              outcome = ST_NO_FORMAT;
            end else begin
              value_cap = (announced < desc_count) ? announced : desc_count;
            end
          end else if (p >= 6) begin
            go = 1'b1;
            if (bytes_left == 0) begin
              if (value_num >= value_cap || value_num >= SFD_BUFFER_BYTES) begin
                go = 1'b0;
              end else begin
                n = value_bytes(desc_table[value_num][1:0]);
                if (p + n > frame_len - 1) begin
                  phase = FK_HEADER;
                  outcome = ST_TRUNCATED;
                  go = 1'b0;
                end else begin
                  bytes_left = n;
                  accum = '0;
                end
              end
            end
            if (go) begin
              accum = {accum[23:0], b};
              bytes_left--;
              if (bytes_left == 0) begin
                d = desc_table[value_num];
                n = value_bytes(d[1:0]);
                scale = SCALE_BY_INDEX[d[5:2]];
                sv = accum;
                if (d[6] && n == 1 && accum[7]) sv = accum | 32'hFFFFFF00;
                if (d[6] && n == 2 && accum[15]) sv = accum | 32'hFFFF0000;
                r.kind = RK_VALUE;
                r.index = 6'(value_num);
                r.raw = accum;
                r.sval = sv;
                r.div = scale;
                r.sgn = d[6];
                r.flt = (scale != 1);
                r.blen = 3'(n);
                emit = 1'b1;
                value_num++;
              end
            end
          end
        end
        default: ;
      endcase
    end
    if (p + 1 >= frame_len) begin
      cnt = value_num;
      if (frame_len < 7) begin
        st = (frame_len >= 3) ? ST_BAD_HEADER : ST_TOO_SHORT;
      end else if (phase == FK_FORMAT) begin
        st = ST_FORMAT_STORED;
        format_ok = 1'b1;
        cnt = desc_count;
      end else if (phase == FK_VALUES) begin
        st = (value_num >= value_cap) ? ST_VALUES_DONE : ST_TRUNCATED;
      end else begin
        st = outcome;
      end
      r = '0;
      r.kind = RK_STATUS;
      r.status = st;
      r.count = 7'(cnt);
      emit = 1'b1;
      phase = FK_NONE;
    end else begin
      byte_pos++;
    end
    if (emit) decoded_results.insert(decoded_results.size(), r);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    decoded_t want;
    if (rst) begin
      decoded_results.delete();
      desc_count = 0;
      format_ok = 1'b0;
      byte_pos = 0;
      phase = FK_NONE;
      announced = '0;
      accum = '0;
      value_num = 0;
      bytes_left = 0;
      outcome = OUTCOME_NONE;
      frame_len = 1;
      value_cap = 0;
      mismatches = 0;
    end else begin
      if (result_valid && result_ready) begin
        if (decoded_results.size() == 0) begin
          $error("result accepted with no prediction pending");
          mismatches++;
        end else begin
          want = decoded_results.pop_front();
          check_field("result_kind", want.kind, result_kind);
          check_field("value_index", want.index, value_index);
          check_field("value_raw", want.raw, value_raw);
          check_field("value_ext", want.sval, value_ext);
          check_field("divider", want.div, divider);
          check_field("sign_flag", want.sgn, sign_flag);
          check_field("scaled_flag", want.flt, scaled_flag);
          check_field("byte_length", want.blen, byte_length);
          check_field("frame_status", want.status, frame_status);
          check_field("item_count", want.count, item_count);
        end
      end
      // result first: a byte taken now cannot answer in the same cycle
      if (byte_valid && byte_ready) decode_reply_byte(rx_byte, frame_start, frame_length);
    end
    results_due = decoded_results.size();
  end

endmodule

FILE: bench/status_frame_decoder_unit_tb.sv
// ----------------------------------------------------------------------------
// Status frame decoder testbench
// Sends short directed frames, then random format, values and broken
// frames with random idle gaps on both channels; the checker predicts and
// compares every result and this top reports the verdict.
// ----------------------------------------------------------------------------
module status_frame_decoder_unit_tb;
  import sfd_pkg::*;

  localparam int RAND_BYTES   = 850;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;

  logic               clk;
  logic               rst;
  logic               byte_valid;
  logic               byte_ready;
  logic [7:0]         rx_byte;
  logic               frame_start;
  logic [6:0]         frame_length;
  logic               result_valid;
  logic               result_ready;
  logic               result_kind;
  logic [5:0]         value_index;
  logic [31:0]        value_raw;
  logic signed [31:0] value_ext;
  logic [DIV_W-1:0]   divider;
  logic               sign_flag;
  logic               scaled_flag;
  logic [2:0]         byte_length;
  logic [2:0]         frame_status;
  logic [6:0]         item_count;
  int                 mismatches;
  int                 results_due;

  logic [7:0] frame_q[$];
  int         fmt_len [SFD_BUFFER_BYTES];
  int         fmt_n;
  bit         fmt_ok;
  int         sent_bytes;
  bit         tx_quiet;
  int         tx_run_left;
  int         cycles;

  status_frame_decoder_unit dut (.*);

  status_frame_decoder_unit_checker checker_i (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  // result side: random stall per result, with runs of no stalling
  initial begin
    int stall;
    int run_left;
    bit quiet;
    result_ready = 1'b0;
    run_left = 0;
    quiet = 1'b0;
    @(posedge clk);
    forever begin
      if (run_left == 0) begin
        quiet = ($urandom_range(0, 5) == 0);
        run_left = $urandom_range(5, 40);
      end
      run_left--;
      stall = quiet ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
    end
  end

  // one byte request; returns at the edge that accepted it
  task automatic send_byte(input logic [7:0] b, input logic s, input logic [6:0] l);
    int gap;
    if (tx_run_left == 0) begin
      tx_quiet = ($urandom_range(0, 5) == 0);
      tx_run_left = $urandom_range(5, 40);
    end
    tx_run_left--;
    gap = tx_quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_valid <= 1'b1;
    rx_byte <= b;
    frame_start <= s;
    frame_length <= l;
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
  endtask

  task automatic send_frame(input logic [6:0] len_field, input int keep);
    for (int i = 0; i < keep; i++) send_byte(frame_q[i], i == 0, len_field);
    sent_bytes += keep;
  endtask

  task automatic wait_drained();
    byte_valid <= 1'b0;
    do @(negedge clk); while (results_due != 0);
    @(posedge clk);
  endtask

  function automatic void append_byte(input logic [7:0] b);
    frame_q.insert(frame_q.size(), b);
  endfunction

  function automatic logic [7:0] rand_data();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // datatype byte whose decoded length is nbytes
  function automatic logic [7:0] pick_datatype(input int nbytes);
    logic [2:0] hi;
    logic [7:0] dt;
    int sel;
    sel = $urandom_range(0, 4);
    case (nbytes)
      2: hi = 3'd1;
      4: hi = sel[0] ? 3'd2 : 3'd7;
      default: hi = (sel == 0) ? 3'd0 : 3'(sel + 2);
    endcase
    dt = {1'($urandom_range(0, 1)), hi, 4'($urandom_range(0, 15))};
    if (nbytes == 2 && $urandom_range(0, 5) == 0) dt = DT_SPECIAL;
    else if (dt == DT_SPECIAL) dt = {dt[7:1], 1'b0};
    return dt;
  endfunction

  task automatic build_header(input logic [7:0] kind_byte, input logic [7:0] count);
    frame_q.delete();
    append_byte(8'($urandom));
    append_byte(HDR_BYTE1);
    append_byte(HDR_BYTE2);
    append_byte(kind_byte);
    append_byte(8'($urandom));
    append_byte(count);
  endtask

  task automatic build_format();
    int n;
    int k;
    int sum;
    int c;
    int sel;
    int extra;
    int ann;
    bit big;
    big = ($urandom_range(0, 9) == 0);
    n = big ? $urandom_range(20, 57) : $urandom_range(0, 12);
    k = 0;
    sum = 0;
    while (k < n) begin
      sel = $urandom_range(0, 2);
      c = (sel == 0) ? 1 : ((sel == 1) ? 2 : 4);
      if (big && $urandom_range(0, 3) != 0) c = 1;
      if (sum + c > 57) break;
      fmt_len[k] = c;
      sum += c;
      k++;
    end
    extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    if (k + extra > 57) extra = 57 - k;
    for (int i = 0; i < extra; i++) fmt_len[k + i] = 1;
    sel = $urandom_range(0, 9);
    ann = (sel == 0) ? $urandom_range(0, 255) :
          ((sel == 1 && k > 0) ? $urandom_range(0, k - 1) : k);
    build_header(KIND_FORMAT, 8'(ann));
    for (int i = 0; i < k + extra; i++) append_byte(pick_datatype(fmt_len[i]));
    append_byte(8'($urandom));
    fmt_n = (ann < k + extra) ? ann : k + extra;
    fmt_ok = 1'b1;
  endtask

  task automatic build_values();
    int n;
    int ann;
    int use_n;
    int sum;
    int sel;
    int extra;
    n = fmt_ok ? fmt_n : $urandom_range(0, 8);
    sel = $urandom_range(0, 9);
    ann = (sel == 0) ? $urandom_range(0, 255) :
          ((sel == 1 && n > 0) ? $urandom_range(0, n - 1) : n);
    use_n = (ann < n) ? ann : n;
    sum = 0;
    for (int i = 0; i < use_n; i++) sum += fmt_ok ? fmt_len[i] : 1;
    extra = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
    if (sum > 57) sum = 57;
    if (sum + extra > 57) extra = 57 - sum;
    build_header(KIND_VALUES, 8'(ann));
    repeat (sum + extra) append_byte(rand_data());
    append_byte(8'($urandom));
  endtask

  initial begin
    int sel;
    int n;
    int keep;
    bit as_format;
    clk = 1'b0;
    rst = 1'b1;
    byte_valid = 1'b0;
    rx_byte = '0;
    frame_start = 1'b0;
    frame_length = 7'd1;
    fmt_ok = 1'b0;
    fmt_n = 0;
    sent_bytes = 0;
    tx_quiet = 1'b0;
    tx_run_left = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // too short with a zero length field, too short, bad header
    frame_q = {8'h00};
    send_frame(7'd0, 1);
    frame_q = {8'hFF, 8'hFF};
    send_frame(7'd2, 2);
    frame_q = {8'h00, HDR_BYTE1, HDR_BYTE2};
    send_frame(7'd3, 3);
    // byte outside any frame
    send_byte(8'hFF, 1'b0, 7'd127);
    // format: special 2-byte type, signed 4-byte type with the largest divider
    frame_q = {8'h00, HDR_BYTE1, HDR_BYTE2, KIND_FORMAT, 8'h00, 8'd2,
               DT_SPECIAL, 8'hF8, 8'hFF};
    send_frame(7'd9, 9);
    fmt_ok = 1'b1;
    fmt_n = 2;
    fmt_len[0] = 2;
    fmt_len[1] = 4;
    frame_q = {8'hFF, HDR_BYTE1, HDR_BYTE2, KIND_VALUES, 8'hFF, 8'd2,
               8'hFF, 8'hFF, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00};
    send_frame(7'd13, 13);
    wait_drained();

    sent_bytes = 0;
    while (sent_bytes < RAND_BYTES) begin
      sel = $urandom_range(0, 99);
      as_format = ($urandom_range(0, 1) == 1);
      if (sel < 30) begin
        build_format();
        send_frame(7'(frame_q.size()), frame_q.size());
      end else if (sel < 65) begin
        build_values();
        send_frame(7'(frame_q.size()), frame_q.size());
      end else if (sel < 70) begin
        n = $urandom_range(0, 6);
        frame_q.delete();
        repeat ((n == 0) ? 1 : n) append_byte(8'($urandom));
        send_frame(7'(n), (n == 0) ? 1 : n);
      end else if (sel < 76) begin
        if (as_format) build_format();
        else build_values();
        n = $urandom_range(1, 3);
        frame_q[n] = frame_q[n] ^ 8'($urandom_range(1, 255));
        if (as_format) fmt_ok = 1'b0;
        send_frame(7'(frame_q.size()), frame_q.size());
      end else if (sel < 83) begin
        // restart before the end of the running frame
        if (as_format) begin
          build_format();
          keep = $urandom_range(6, frame_q.size() - 1);
          fmt_ok = 1'b0;
        end else begin
          build_values();
          keep = $urandom_range(1, frame_q.size() - 1);
        end
        send_frame(7'(frame_q.size()), keep);
      end else if (sel < 89) begin
        // length field too small for the values; tail falls outside the frame
        build_values();
        n = $urandom_range(1, 3);
        send_frame(7'(frame_q.size() - n), frame_q.size());
      end else if (sel < 94) begin
        if (as_format) build_format();
        else build_values();
        if (as_format) fmt_ok = 1'b0;
        while (frame_q.size() < SFD_BUFFER_BYTES) append_byte(rand_data());
        send_frame(7'($urandom_range(SFD_BUFFER_BYTES, 127)), SFD_BUFFER_BYTES);
      end else begin
        build_header(KIND_FORMAT, 8'($urandom));
        append_byte(8'($urandom));
        fmt_ok = 1'b1;
        fmt_n = 0;
        send_frame(7'(frame_q.size()), frame_q.size());
      end
      if ($urandom_range(0, 7) == 0)
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, 7'($urandom));
      if ($urandom_range(0, 24) == 0) wait_drained();
    end

    byte_valid <= 1'b0;
    do @(negedge clk); while (results_due != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && results_due == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/sfd_pkg.sv
rtl/sfd_ram.sv
rtl/status_frame_decoder_unit.sv
bench/status_frame_decoder_unit_checker.sv
bench/status_frame_decoder_unit_tb.sv
